// ===== design/bsc_pkg.sv =====
`timescale 1ns / 1ps

package bsc_pkg;

   localparam int MAX_PROCESSES = 16;
   localparam int MAX_RESOURCES = 8;
   localparam int VALUE_WIDTH   = 16;

   localparam int ROW_WIDTH       = $clog2(MAX_PROCESSES);
   localparam int COL_WIDTH       = $clog2(MAX_RESOURCES);
   localparam int ROW_COUNT_WIDTH = $clog2(MAX_PROCESSES + 1);
   localparam int COL_COUNT_WIDTH = $clog2(MAX_RESOURCES + 1);
   localparam int TABLE_DEPTH     = MAX_PROCESSES * MAX_RESOURCES;
   localparam int TABLE_AW        = $clog2(TABLE_DEPTH);
   // available plus every allocation, summed
   localparam int WORK_WIDTH      = VALUE_WIDTH + ROW_COUNT_WIDTH;

   // fixed register and field widths
   localparam int NP_WIDTH        = 5;
   localparam int NR_WIDTH        = 4;
   localparam int CSR_DATA_WIDTH  = 5;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int MODE_WIDTH      = 2;
   localparam int PINDEX_WIDTH    = 4;
   localparam int RINDEX_WIDTH    = 3;
   localparam int PID_WIDTH       = 4;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_LOAD_ALLOC = 2'd0,
      MODE_LOAD_MAX   = 2'd1,
      MODE_LOAD_AVAIL = 2'd2,
      MODE_RUN        = 2'd3
   } mode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_NUM_PROCESSES = 1'b0,
      CSR_NUM_RESOURCES = 1'b1
   } csr_index_type;

   typedef logic [MAX_RESOURCES-1:0][VALUE_WIDTH-1:0] avail_vec_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] alloc_q;
      logic [VALUE_WIDTH-1:0] max_q;
   } table_q_type;

endpackage

// ===== design/bsc_ram.sv =====
`timescale 1ns / 1ps

module bsc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/bsc_engine.sv =====
`timescale 1ns / 1ps

module bsc_engine
   import bsc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       run,
   input  logic [ROW_COUNT_WIDTH-1:0] rows,
   input  logic [COL_COUNT_WIDTH-1:0] cols,
   input  avail_vec_type              avail,
   input  table_q_type                table_q,
   output logic [TABLE_AW-1:0]        rd_addr,
   output logic                       busy,
   output logic                       rsp_strobe,
   output logic                       rsp_safe_flag,
   output logic [PID_WIDTH-1:0]       rsp_process_id,
   output logic                       rsp_last
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SCAN = 5'b00010,
      ST_FIT  = 5'b00100,
      ST_ADD  = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   state_type                  state_ff, state_in;
   logic [ROW_COUNT_WIDTH-1:0] row_ff, row_in;
   logic [COL_COUNT_WIDTH-1:0] col_ff, col_in;
   logic [ROW_COUNT_WIDTH-1:0] pass_ff, pass_in;
   logic                       progress_ff, progress_in;
   logic                       fail_ff, fail_in;
   logic                       rd_valid_ff, rd_valid_in;
   logic [COL_WIDTH-1:0]       rd_col_ff, rd_col_in;
   logic [MAX_PROCESSES-1:0]   finished_ff, finished_in;
   logic [ROW_COUNT_WIDTH-1:0] order_count_ff, order_count_in;
   logic [WORK_WIDTH-1:0]      work_ff [MAX_RESOURCES];
   logic [WORK_WIDTH-1:0]      work_in [MAX_RESOURCES];
   logic [ROW_WIDTH-1:0]       order_ff [MAX_PROCESSES];
   logic                       order_we;
   logic                       strobe_ff, strobe_in;
   logic                       safe_ff, safe_in;
   logic [PID_WIDTH-1:0]       pid_ff, pid_in;
   logic                       last_ff, last_in;

   logic                       issue;
   logic [WORK_WIDTH:0]        fit_sum;
   logic                       violation;
   logic                       sweep_done;

   assign rd_addr    = {row_ff[ROW_WIDTH-1:0], col_ff[COL_WIDTH-1:0]};
   assign issue      = (col_ff != cols);
   assign fit_sum    = (WORK_WIDTH+1)'(work_ff[rd_col_ff]) + (WORK_WIDTH+1)'(table_q.alloc_q);
   assign violation  = rd_valid_ff && ((WORK_WIDTH+1)'(table_q.max_q) > fit_sum);
   // last column compared or added, nothing left in flight
   assign sweep_done = !issue && rd_valid_ff;

   always_comb begin
      state_in       = state_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      pass_in        = pass_ff;
      progress_in    = progress_ff;
      fail_in        = fail_ff;
      rd_valid_in    = 1'b0;
      rd_col_in      = col_ff[COL_WIDTH-1:0];
      finished_in    = finished_ff;
      order_count_in = order_count_ff;
      work_in        = work_ff;
      order_we       = 1'b0;
      strobe_in      = 1'b0;
      safe_in        = 1'b0;
      pid_in         = '0;
      last_in        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (run) begin
               for (int c = 0; c < MAX_RESOURCES; c++) begin
                  work_in[c] = WORK_WIDTH'(avail[c]);
               end
               finished_in    = '0;
               order_count_in = '0;
               pass_in        = '0;
               row_in         = '0;
               progress_in    = 1'b0;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (row_ff == rows) begin
               // end of pass
               row_in = '0;
               if (!progress_ff || (pass_ff + ROW_COUNT_WIDTH'(1)) == rows) begin
                  state_in = ST_EMIT;
               end else begin
                  pass_in     = pass_ff + ROW_COUNT_WIDTH'(1);
                  progress_in = 1'b0;
               end
            end else if (finished_ff[row_ff[ROW_WIDTH-1:0]]) begin
               row_in = row_ff + ROW_COUNT_WIDTH'(1);
            end else begin
               col_in   = '0;
               fail_in  = 1'b0;
               state_in = ST_FIT;
            end
         end
         ST_FIT: begin
            rd_valid_in = issue;
            if (issue) begin
               col_in = col_ff + COL_COUNT_WIDTH'(1);
            end
            if (violation) begin
               fail_in = 1'b1;
            end
            if (sweep_done) begin
               if (fail_ff || violation) begin
                  row_in   = row_ff + ROW_COUNT_WIDTH'(1);
                  state_in = ST_SCAN;
               end else begin
                  col_in   = '0;
                  state_in = ST_ADD;
               end
            end
         end
         ST_ADD: begin
            rd_valid_in = issue;
            if (issue) begin
               col_in = col_ff + COL_COUNT_WIDTH'(1);
            end
            if (rd_valid_ff) begin
               work_in[rd_col_ff] = work_ff[rd_col_ff] + WORK_WIDTH'(table_q.alloc_q);
            end
            if (sweep_done) begin
               finished_in[row_ff[ROW_WIDTH-1:0]] = 1'b1;
               order_we       = 1'b1;
               order_count_in = order_count_ff + ROW_COUNT_WIDTH'(1);
               progress_in    = 1'b1;
               row_in         = row_ff + ROW_COUNT_WIDTH'(1);
               state_in       = ST_SCAN;
            end
         end
         ST_EMIT: begin
            strobe_in = 1'b1;
            if (order_count_ff != rows) begin
               // deadlock: a single beat
               last_in  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               safe_in = 1'b1;
               pid_in  = PID_WIDTH'(order_ff[row_ff[ROW_WIDTH-1:0]]);
               if ((row_ff + ROW_COUNT_WIDTH'(1)) == order_count_ff) begin
                  last_in  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  row_in = row_ff + ROW_COUNT_WIDTH'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         row_ff         <= '0;
         col_ff         <= '0;
         pass_ff        <= '0;
         progress_ff    <= 1'b0;
         fail_ff        <= 1'b0;
         rd_valid_ff    <= 1'b0;
         finished_ff    <= '0;
         order_count_ff <= '0;
         strobe_ff      <= 1'b0;
         for (int c = 0; c < MAX_RESOURCES; c++) begin
            work_ff[c] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         row_ff         <= row_in;
         col_ff         <= col_in;
         pass_ff        <= pass_in;
         progress_ff    <= progress_in;
         fail_ff        <= fail_in;
         rd_valid_ff    <= rd_valid_in;
         finished_ff    <= finished_in;
         order_count_ff <= order_count_in;
         strobe_ff      <= strobe_in;
         work_ff        <= work_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_col_ff <= rd_col_in;
      safe_ff   <= safe_in;
      pid_ff    <= pid_in;
      last_ff   <= last_in;
      if (order_we) begin
         order_ff[order_count_ff[ROW_WIDTH-1:0]] <= row_ff[ROW_WIDTH-1:0];
      end
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = strobe_ff;
   assign rsp_safe_flag  = safe_ff;
   assign rsp_process_id = pid_ff;
   assign rsp_last       = last_ff;

endmodule

// ===== design/bankers_safety_check.sv =====
`timescale 1ns / 1ps

// Banker's algorithm safety check. Load beats (allocation, max claim, available) are taken
// one per cycle while busy is low and give no result. A run beat raises busy and walks the
// tables through the shared read address of the two table memories, one entry per cycle: in
// each pass a finished process is skipped, an unfinished one is compared column by column
// and, if it fits, has its allocation added to the work vector column by column; at most
// num_processes passes run. Results then follow one per cycle, num_processes beats for a
// safe state or one deadlock beat, each on rsp_strobe for a single cycle with no way to
// hold it off; the final beat carries rsp_last.

module bankers_safety_check
   import bsc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [MODE_WIDTH-1:0]      req_mode,
   input  logic [PINDEX_WIDTH-1:0]    req_process_index,
   input  logic [RINDEX_WIDTH-1:0]    req_resource_index,
   input  logic [VALUE_WIDTH-1:0]     req_value,
   output logic                       rsp_strobe,
   output logic                       rsp_safe_flag,
   output logic [PID_WIDTH-1:0]       rsp_process_id,
   output logic                       rsp_last,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wr_data
);

   logic [NP_WIDTH-1:0]        num_processes_ff;
   logic [NR_WIDTH-1:0]        num_resources_ff;
   avail_vec_type              avail_ff;
   logic                       accept;
   logic                       load_alloc;
   logic                       load_max;
   logic                       load_avail;
   logic                       run;
   logic [TABLE_AW-1:0]        wr_addr;
   logic [TABLE_AW-1:0]        rd_addr;
   logic [ROW_COUNT_WIDTH-1:0] rows;
   logic [COL_COUNT_WIDTH-1:0] cols;
   table_q_type                table_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_processes_ff <= NP_WIDTH'(1);
         num_resources_ff <= NR_WIDTH'(1);
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_NUM_PROCESSES: num_processes_ff <= csr_wr_data[NP_WIDTH-1:0];
            CSR_NUM_RESOURCES: num_resources_ff <= csr_wr_data[NR_WIDTH-1:0];
         endcase
      end
   end

   // out-of-range register values saturate
   always_comb begin
      priority if (num_processes_ff == '0) begin
         rows = ROW_COUNT_WIDTH'(1);
      end else if (32'(num_processes_ff) > MAX_PROCESSES) begin
         rows = ROW_COUNT_WIDTH'(MAX_PROCESSES);
      end else begin
         rows = ROW_COUNT_WIDTH'(num_processes_ff);
      end
      priority if (num_resources_ff == '0) begin
         cols = COL_COUNT_WIDTH'(1);
      end else if (32'(num_resources_ff) > MAX_RESOURCES) begin
         cols = COL_COUNT_WIDTH'(MAX_RESOURCES);
      end else begin
         cols = COL_COUNT_WIDTH'(num_resources_ff);
      end
   end

   assign accept     = start && !busy;
   assign load_alloc = accept && (req_mode == MODE_LOAD_ALLOC);
   assign load_max   = accept && (req_mode == MODE_LOAD_MAX);
   assign load_avail = accept && (req_mode == MODE_LOAD_AVAIL);
   assign run        = accept && (req_mode == MODE_RUN);
   assign wr_addr    = {req_process_index[ROW_WIDTH-1:0], req_resource_index[COL_WIDTH-1:0]};

   always_ff @(posedge clock) begin
      if (load_avail) begin
         avail_ff[req_resource_index[COL_WIDTH-1:0]] <= req_value;
      end
   end

   bsc_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_alloc_ram (
      .clock   (clock),
      .wr_en   (load_alloc),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (rd_addr),
      .rd_data (table_q.alloc_q)
   );

   bsc_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_max_ram (
      .clock   (clock),
      .wr_en   (load_max),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (rd_addr),
      .rd_data (table_q.max_q)
   );

   bsc_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .run            (run),
      .rows           (rows),
      .cols           (cols),
      .avail          (avail_ff),
      .table_q        (table_q),
      .rd_addr        (rd_addr),
      .busy           (busy),
      .rsp_strobe     (rsp_strobe),
      .rsp_safe_flag  (rsp_safe_flag),
      .rsp_process_id (rsp_process_id),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== tb/bankers_safety_check_tb.sv =====
`timescale 1ns / 1ps

module bankers_safety_check_tb;
   import bsc_pkg::*;

   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 20;
   localparam int ITEM_COUNT    = 160;

   typedef struct {
      logic                 safe_flag;
      logic [PID_WIDTH-1:0] process_id;
      logic                 last;
   } order_beat_type;

   class safety_scoreboard;
      logic [VALUE_WIDTH-1:0] alloc_t [MAX_PROCESSES][MAX_RESOURCES];
      logic [VALUE_WIDTH-1:0] claim_t [MAX_PROCESSES][MAX_RESOURCES];
      logic [VALUE_WIDTH-1:0] avail_v [MAX_RESOURCES];
      bit                     alloc_loaded [MAX_PROCESSES][MAX_RESOURCES];
      bit                     claim_loaded [MAX_PROCESSES][MAX_RESOURCES];
      bit                     avail_loaded [MAX_RESOURCES];
      logic [NP_WIDTH-1:0]    num_processes = 1;
      logic [NR_WIDTH-1:0]    num_resources = 1;
      order_beat_type         expected_order [$];
      int                     errors = 0;

      function int rows_in_use();
         if (num_processes == 0) return 1;
         if (int'(num_processes) > MAX_PROCESSES) return MAX_PROCESSES;
         return int'(num_processes);
      endfunction

      function int cols_in_use();
         if (num_resources == 0) return 1;
         if (int'(num_resources) > MAX_RESOURCES) return MAX_RESOURCES;
         return int'(num_resources);
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_WIDTH-1:0] data);
         if (idx == CSR_NUM_PROCESSES) num_processes = data[NP_WIDTH-1:0];
         else num_resources = data[NR_WIDTH-1:0];
      endfunction

      // repeated passes over the rows, at most one per row, until one pass releases nothing
      function void predict_order();
         logic [WORK_WIDTH-1:0]    work [MAX_RESOURCES];
         logic [MAX_PROCESSES-1:0] finished;
         logic [PID_WIDTH-1:0]     order [$];
         int                       rows;
         int                       cols;
         bit                       progress;
         bit                       fit;
         order_beat_type           beat;
         rows = rows_in_use();
         cols = cols_in_use();
         finished = '0;
         for (int c = 0; c < cols; c++) work[c] = WORK_WIDTH'(avail_v[c]);
         for (int pass = 0; pass < rows; pass++) begin
            progress = 0;
            for (int row = 0; row < rows; row++) begin
               if (!finished[row]) begin
                  fit = 1;
                  // claim below allocation always fits
                  for (int c = 0; c < cols; c++)
                     if (WORK_WIDTH'(claim_t[row][c]) > work[c] + WORK_WIDTH'(alloc_t[row][c]))
                        fit = 0;
                  if (fit) begin
                     for (int c = 0; c < cols; c++)
                        work[c] = work[c] + WORK_WIDTH'(alloc_t[row][c]);
                     finished[row] = 1'b1;
                     order.push_back(PID_WIDTH'(row));
                     progress = 1;
                  end
               end
            end
            if (!progress) break;
         end
         if (order.size() < rows) begin
            beat.safe_flag  = 1'b0;
            beat.process_id = '0;
            beat.last       = 1'b1;
            expected_order.push_back(beat);
         end else begin
            foreach (order[k]) begin
               beat.safe_flag  = 1'b1;
               beat.process_id = order[k];
               beat.last       = (k == order.size() - 1);
               expected_order.push_back(beat);
            end
         end
      endfunction

      function void note_beat(mode_type mode, logic [PINDEX_WIDTH-1:0] p,
                              logic [RINDEX_WIDTH-1:0] r, logic [VALUE_WIDTH-1:0] v);
         case (mode)
            MODE_LOAD_ALLOC: begin
               alloc_t[p][r] = v;
               alloc_loaded[p][r] = 1;
            end
            MODE_LOAD_MAX: begin
               claim_t[p][r] = v;
               claim_loaded[p][r] = 1;
            end
            MODE_LOAD_AVAIL: begin
               avail_v[r] = v;
               avail_loaded[r] = 1;
            end
            default: predict_order();
         endcase
      endfunction

      function void check_result(logic safe_flag, logic [PID_WIDTH-1:0] process_id,
                                 logic last);
         order_beat_type want;
         if (expected_order.size() == 0) begin
            $error("unexpected result: safe_flag %0d process_id %0d last %0d",
                   safe_flag, process_id, last);
            errors++;
            return;
         end
         want = expected_order.pop_front();
         if (safe_flag !== want.safe_flag) begin
            $error("safe_flag: expected %0d, got %0d", want.safe_flag, safe_flag);
            errors++;
         end
         if (process_id !== want.process_id) begin
            $error("process_id: expected %0d, got %0d", want.process_id, process_id);
            errors++;
         end
         if (last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic [MODE_WIDTH-1:0]      req_mode;
   logic [PINDEX_WIDTH-1:0]    req_process_index;
   logic [RINDEX_WIDTH-1:0]    req_resource_index;
   logic [VALUE_WIDTH-1:0]     req_value;
   logic                       rsp_strobe;
   logic                       rsp_safe_flag;
   logic [PID_WIDTH-1:0]       rsp_process_id;
   logic                       rsp_last;
   logic                       csr_wr_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wr_data;

   safety_scoreboard board;
   int               gap_limit;
   int               beats_sent;

   bankers_safety_check uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_process_index  (req_process_index),
      .req_resource_index (req_resource_index),
      .req_value          (req_value),
      .rsp_strobe         (rsp_strobe),
      .rsp_safe_flag      (rsp_safe_flag),
      .rsp_process_id     (rsp_process_id),
      .rsp_last           (rsp_last),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("bankers_safety_check_tb: errors");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) board.check_result(rsp_safe_flag, rsp_process_id, rsp_last);
   end

   // start stays high across back-to-back beats
   task automatic send_beat(mode_type mode, logic [PINDEX_WIDTH-1:0] p,
                            logic [RINDEX_WIDTH-1:0] r, logic [VALUE_WIDTH-1:0] v);
      int gap;
      gap = $urandom_range(0, gap_limit);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start              <= 1'b1;
      req_mode           <= mode;
      req_process_index  <= p;
      req_resource_index <= r;
      req_value          <= v;
      do @(posedge clock); while (busy);
      board.note_beat(mode, p, r, v);
      beats_sent++;
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (board.expected_order.size() != 0 || busy);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_registers(logic [CSR_DATA_WIDTH-1:0] np_data,
                                  logic [CSR_DATA_WIDTH-1:0] nr_data);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_NUM_PROCESSES;
      csr_wr_data <= np_data;
      @(posedge clock);
      board.write_register(CSR_NUM_PROCESSES, np_data);
      csr_index   <= CSR_NUM_RESOURCES;
      csr_wr_data <= nr_data;
      @(posedge clock);
      board.write_register(CSR_NUM_RESOURCES, nr_data);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [VALUE_WIDTH-1:0] pick_count();
      case ($urandom_range(0, 9))
         0:       return '1;
         1:       return '0;
         2, 3:    return VALUE_WIDTH'($urandom);
         default: return VALUE_WIDTH'($urandom_range(0, 5));
      endcase
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] pick_avail();
      if ($urandom_range(0, 9) < 7) return VALUE_WIDTH'($urandom_range(0, 8));
      return pick_count();
   endfunction

   // mostly a claim at or just above the allocation, so that runs stay safe often
   function automatic logic [VALUE_WIDTH-1:0] pick_claim(int p, int r);
      logic [VALUE_WIDTH:0] sum;
      if (!board.alloc_loaded[p][r] || $urandom_range(0, 9) < 2) return pick_count();
      if ($urandom_range(0, 9) == 0)
         return board.alloc_t[p][r] - VALUE_WIDTH'($urandom_range(0, 2));
      sum = (VALUE_WIDTH+1)'(board.alloc_t[p][r]) + (VALUE_WIDTH+1)'($urandom_range(0, 3));
      return sum[VALUE_WIDTH] ? '1 : sum[VALUE_WIDTH-1:0];
   endfunction

   // every entry a run reads is loaded first
   task automatic run_check();
      logic [VALUE_WIDTH-1:0] held;
      for (int p = 0; p < board.rows_in_use(); p++) begin
         for (int r = 0; r < board.cols_in_use(); r++) begin
            if (!board.alloc_loaded[p][r])
               send_beat(MODE_LOAD_ALLOC, PINDEX_WIDTH'(p), RINDEX_WIDTH'(r),
                         VALUE_WIDTH'($urandom_range(0, 4)));
            if (!board.claim_loaded[p][r]) begin
               held = board.alloc_t[p][r];
               if ($urandom_range(0, 9) == 0) held = held - VALUE_WIDTH'($urandom_range(0, 2));
               else held = held + VALUE_WIDTH'($urandom_range(0, 3));
               send_beat(MODE_LOAD_MAX, PINDEX_WIDTH'(p), RINDEX_WIDTH'(r), held);
            end
         end
      end
      for (int r = 0; r < board.cols_in_use(); r++)
         if (!board.avail_loaded[r])
            send_beat(MODE_LOAD_AVAIL, PINDEX_WIDTH'($urandom), RINDEX_WIDTH'(r),
                      VALUE_WIDTH'($urandom_range(0, 3)));
      send_beat(MODE_RUN, PINDEX_WIDTH'($urandom), RINDEX_WIDTH'($urandom),
                VALUE_WIDTH'($urandom));
   endtask

   initial begin
      logic [CSR_DATA_WIDTH-1:0] np_data;
      logic [CSR_DATA_WIDTH-1:0] nr_data;
      mode_type                  mode;
      int                        p;
      int                        r;
      logic [VALUE_WIDTH-1:0]    v;

      board = new();
      gap_limit = 10;
      beats_sent = 0;
      reset              <= 1'b1;
      start              <= 1'b0;
      req_mode           <= MODE_LOAD_ALLOC;
      req_process_index  <= '0;
      req_resource_index <= '0;
      req_value          <= '0;
      csr_wr_en          <= 1'b0;
      csr_index          <= CSR_NUM_PROCESSES;
      csr_wr_data        <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      write_registers(5'd1, 5'd1);
      // claim below allocation fits with nothing available
      send_beat(MODE_LOAD_ALLOC, 4'h0, 3'h0, 16'hFFFF);
      send_beat(MODE_LOAD_MAX, 4'h0, 3'h0, 16'h0000);
      send_beat(MODE_LOAD_AVAIL, 4'h0, 3'h0, 16'h0000);
      send_beat(MODE_RUN, 4'hF, 3'h7, 16'hFFFF);
      // one unit short gives a deadlock
      send_beat(MODE_LOAD_ALLOC, 4'h0, 3'h0, 16'h0000);
      send_beat(MODE_LOAD_MAX, 4'h0, 3'h0, 16'hFFFF);
      send_beat(MODE_LOAD_AVAIL, 4'hF, 3'h0, 16'hFFFE);
      send_beat(MODE_RUN, 4'h0, 3'h0, 16'h0000);
      send_beat(MODE_LOAD_AVAIL, 4'h5, 3'h0, 16'hFFFF);
      send_beat(MODE_RUN, 4'hA, 3'h5, 16'h5A5A);

      // zero counts saturate up to one
      write_registers(5'd0, 5'd0);
      send_beat(MODE_RUN, 4'h5, 3'h2, 16'hA5A5);

      // second pass needed: process 0 waits for process 1 to release; bit 4 of the
      // resource count is dropped
      write_registers(5'd2, 5'b10001);
      send_beat(MODE_LOAD_MAX, 4'h0, 3'h0, 16'd5);
      send_beat(MODE_LOAD_ALLOC, 4'h1, 3'h0, 16'd5);
      send_beat(MODE_LOAD_MAX, 4'h1, 3'h0, 16'd5);
      send_beat(MODE_LOAD_AVAIL, 4'h0, 3'h0, 16'd0);
      send_beat(MODE_RUN, 4'h3, 3'h4, 16'h00FF);

      // counts beyond the tables saturate at the full size
      write_registers(5'd31, 5'd1);
      run_check();
      write_registers(5'd1, 5'd31);
      run_check();
      // last row of the tables
      write_registers(5'd16, 5'd1);
      send_beat(MODE_LOAD_ALLOC, 4'hF, 3'h0, 16'h0001);
      send_beat(MODE_LOAD_MAX, 4'hF, 3'h0, 16'h0003);
      run_check();

      while (beats_sent < ITEM_COUNT) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: np_data = CSR_DATA_WIDTH'($urandom_range(1, 5));
            6:                np_data = 5'd16;
            7:                np_data = CSR_DATA_WIDTH'($urandom);
            default:          np_data = CSR_DATA_WIDTH'($urandom_range(1, 16));
         endcase
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: nr_data = CSR_DATA_WIDTH'($urandom_range(1, 3));
            6:                nr_data = 5'd8;
            7:                nr_data = CSR_DATA_WIDTH'($urandom);
            default:          nr_data = CSR_DATA_WIDTH'($urandom_range(1, 8));
         endcase
         write_registers(np_data, nr_data);
         // some phases run without gaps between beats
         gap_limit = ($urandom_range(0, 3) == 0) ? 0 : 10;
         repeat ($urandom_range(2, 5)) begin
            repeat ($urandom_range(0, 5)) begin
               mode = mode_type'($urandom_range(0, 2));
               p = ($urandom_range(0, 4) != 0) ? $urandom_range(0, board.rows_in_use() - 1)
                                               : $urandom_range(0, MAX_PROCESSES - 1);
               r = ($urandom_range(0, 4) != 0) ? $urandom_range(0, board.cols_in_use() - 1)
                                               : $urandom_range(0, MAX_RESOURCES - 1);
               case (mode)
                  MODE_LOAD_ALLOC: v = pick_count();
                  MODE_LOAD_MAX:   v = pick_claim(p, r);
                  default:         v = pick_avail();
               endcase
               send_beat(mode, PINDEX_WIDTH'(p), RINDEX_WIDTH'(r), v);
            end
            run_check();
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.expected_order.size() == 0)
         $display("bankers_safety_check_tb: clean");
      else
         $display("bankers_safety_check_tb: errors");
      $finish;
   end

endmodule
